// ===== rtl/core/qau_pkg.sv =====
// Package for the quaternion arithmetic unit: operation codes, the control
// word carried down the pipeline, register defaults and width helpers.
// Depends on nothing; every module of the unit imports it.
`default_nettype none

package qau_pkg;

    localparam int COMP_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int GUARD_SHIFT    = 16;
    localparam int DOT_WIDTH      = 32;
    localparam int REG_W          = 32;

    localparam logic [REG_W-1:0] NORM_TOL_RESET = 32'd268;
    localparam logic [REG_W-1:0] UNIT_THR_RESET = 32'd268435;

    localparam logic CFG_NORM_TOL = 1'b0;
    localparam logic CFG_UNIT_THR = 1'b1;

    typedef enum logic [3:0] {
        OP_MUL   = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_SCALE = 4'd3,
        OP_CONJ  = 4'd4,
        OP_NORM  = 4'd5,
        OP_INV   = 4'd6,
        OP_NLERP = 4'd7,
        OP_DOT   = 4'd8
    } op_t;

    typedef struct packed {
        op_t  op;
        logic use_norm;
        logic fell_back;
        logic dot_sat;
    } ctl_t;

    function automatic int qau_max(input int x, input int y);
        return (x > y) ? x : y;
    endfunction

    // Width of the (1.0 - t) operand.
    function automatic int qau_tw(input int cw, input int fb);
        return qau_max(cw, fb + 1) + 1;
    endfunction

    // Width of a rounded intermediate component.
    function automatic int qau_mw(input int cw, input int fb);
        return cw + qau_tw(cw, fb) + 3 - fb;
    endfunction

    // Width of a sum of four squares of intermediate components.
    function automatic int qau_sw(input int cw, input int fb);
        return 2 * qau_mw(cw, fb) + 2;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qau_front.sv =====
// Front pipeline of the quaternion arithmetic unit: products, sums, rounding,
// squares and the tolerance checks, seven stages in all.
// Depends on qau_pkg.
`default_nettype none

module qau_front
    import qau_pkg::*;
#(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  wire logic [REG_W-1:0]                      tol,
    input  wire logic [REG_W-1:0]                      thr,
    input  wire logic                                  in_valid,
    input  wire logic [3:0]                            operation,
    input  wire logic signed [COMP_WIDTH-1:0]          a_x,
    input  wire logic signed [COMP_WIDTH-1:0]          a_y,
    input  wire logic signed [COMP_WIDTH-1:0]          a_z,
    input  wire logic signed [COMP_WIDTH-1:0]          a_w,
    input  wire logic signed [COMP_WIDTH-1:0]          b_x,
    input  wire logic signed [COMP_WIDTH-1:0]          b_y,
    input  wire logic signed [COMP_WIDTH-1:0]          b_z,
    input  wire logic signed [COMP_WIDTH-1:0]          b_w,
    input  wire logic signed [COMP_WIDTH-1:0]          blend,
    output logic                                       vld,
    output logic [3:0][qau_mw(COMP_WIDTH, FRAC_BITS)-1:0] pre,
    output logic [DOT_WIDTH-1:0]                       dot,
    output ctl_t                                       ctl,
    output logic [qau_sw(COMP_WIDTH, FRAC_BITS)-1:0]   sum_sq
);

    localparam int CW   = COMP_WIDTH;
    localparam int FB   = FRAC_BITS;
    localparam int TW   = qau_tw(CW, FB);
    localparam int AW   = CW + TW + 2;
    localparam int MW   = qau_mw(CW, FB);
    localparam int SW   = qau_sw(CW, FB);
    localparam int CMPW = qau_max(qau_max(SW, REG_W + 1), 2 * FB + 2);
    localparam int DXW  = qau_max(AW, DOT_WIDTH + 1);

    localparam logic signed [TW-1:0]   ONE_Q  = TW'(1) << FB;
    localparam logic signed [AW:0]     HALF_Q = (AW + 1)'(1) << (FB - 1);
    localparam logic [CMPW-1:0]        UNIT_Q = CMPW'(1) << (2 * FB);

    logic [7:1] vld_reg;

    op_t                      op1_reg;
    logic signed [CW-1:0]     a1_reg [4];
    logic signed [CW-1:0]     b1_reg [4];
    logic signed [CW-1:0]     t1_reg;

    logic signed [TW-1:0]     omt;
    op_t                      op2_reg;
    logic signed [CW-1:0]     a2_reg [4];
    logic signed [CW-1:0]     b2_reg [4];
    logic signed [2*CW-1:0]   hp2_reg [4][4];
    logic signed [2*CW-1:0]   pat2_reg [4];
    logic signed [2*CW-1:0]   pbt2_reg [4];
    logic signed [CW+TW-1:0]  pao2_reg [4];

    logic signed [AW-1:0]     raw3_next [4];
    logic                     rnd3_next;
    logic signed [AW-1:0]     dsum3_next;
    logic signed [AW-1:0]     raw3_reg [4];
    logic                     rnd3_reg;
    logic signed [AW-1:0]     dsum3_reg;
    op_t                      op3_reg;

    logic signed [AW:0]       rs4 [4];
    logic signed [MW-1:0]     pre4_next [4];
    logic signed [DXW-1:0]    dx4;
    logic                     dok4;
    logic [DOT_WIDTH-1:0]     dot4_next;
    logic                     dsat4_next;
    logic signed [MW-1:0]     pre4_reg [4];
    logic [DOT_WIDTH-1:0]     dot4_reg;
    logic                     dsat4_reg;
    op_t                      op4_reg;

    logic [2*MW-1:0]          sq5_reg [4];
    logic signed [MW-1:0]     pre5_reg [4];
    logic [DOT_WIDTH-1:0]     dot5_reg;
    logic                     dsat5_reg;
    op_t                      op5_reg;

    logic [SW-1:0]            s6_reg;
    logic signed [MW-1:0]     pre6_reg [4];
    logic [DOT_WIDTH-1:0]     dot6_reg;
    logic                     dsat6_reg;
    op_t                      op6_reg;

    logic [CMPW-1:0]          sx7;
    logic [CMPW-1:0]          dev7;
    logic                     small7;
    logic                     inv_norm7;
    ctl_t                     ctl7_next;
    logic [SW-1:0]            s7_reg;
    logic signed [MW-1:0]     pre7_reg [4];
    logic [DOT_WIDTH-1:0]     dot7_reg;
    ctl_t                     ctl7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[6:1], in_valid};
        end
    end

    // Stage 1: capture the word.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg   <= op_t'(operation);
            a1_reg[0] <= a_x;
            a1_reg[1] <= a_y;
            a1_reg[2] <= a_z;
            a1_reg[3] <= a_w;
            b1_reg[0] <= b_x;
            b1_reg[1] <= b_y;
            b1_reg[2] <= b_z;
            b1_reg[3] <= b_w;
            t1_reg    <= blend;
        end
    end

    // Stage 2: all products.
    assign omt = ONE_Q - TW'(t1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op2_reg <= op1_reg;
            for (int i = 0; i < 4; i++)
            begin
                a2_reg[i]   <= a1_reg[i];
                b2_reg[i]   <= b1_reg[i];
                pat2_reg[i] <= a1_reg[i] * t1_reg;
                pbt2_reg[i] <= b1_reg[i] * t1_reg;
                pao2_reg[i] <= a1_reg[i] * omt;
                for (int j = 0; j < 4; j++)
                begin
                    hp2_reg[i][j] <= a1_reg[i] * b1_reg[j];
                end
            end
        end
    end

    // Stage 3: sums per operation.
    always_comb
    begin
        rnd3_next  = 1'b0;
        dsum3_next = AW'(hp2_reg[0][0]) + AW'(hp2_reg[1][1])
                   + AW'(hp2_reg[2][2]) + AW'(hp2_reg[3][3]);
        for (int i = 0; i < 4; i++)
        begin
            raw3_next[i] = '0;
        end
        case (op2_reg)
            OP_MUL:
            begin
                rnd3_next    = 1'b1;
                raw3_next[0] = AW'(hp2_reg[1][2]) - AW'(hp2_reg[2][1])
                             + AW'(hp2_reg[3][0]) + AW'(hp2_reg[0][3]);
                raw3_next[1] = AW'(hp2_reg[2][0]) - AW'(hp2_reg[0][2])
                             + AW'(hp2_reg[3][1]) + AW'(hp2_reg[1][3]);
                raw3_next[2] = AW'(hp2_reg[0][1]) - AW'(hp2_reg[1][0])
                             + AW'(hp2_reg[3][2]) + AW'(hp2_reg[2][3]);
                raw3_next[3] = AW'(hp2_reg[3][3]) - (AW'(hp2_reg[0][0])
                             + AW'(hp2_reg[1][1]) + AW'(hp2_reg[2][2]));
            end
            OP_ADD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    raw3_next[i] = AW'(a2_reg[i]) + AW'(b2_reg[i]);
                end
            end
            OP_SUB:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    raw3_next[i] = AW'(a2_reg[i]) - AW'(b2_reg[i]);
                end
            end
            OP_SCALE:
            begin
                rnd3_next = 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    raw3_next[i] = AW'(pat2_reg[i]);
                end
            end
            OP_CONJ:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    raw3_next[i] = -AW'(a2_reg[i]);
                end
                raw3_next[3] = AW'(a2_reg[3]);
            end
            OP_NORM, OP_INV:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    raw3_next[i] = AW'(a2_reg[i]);
                end
            end
            OP_NLERP:
            begin
                rnd3_next = 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    raw3_next[i] = AW'(pao2_reg[i]) + AW'(pbt2_reg[i]);
                end
            end
            default:
            begin
                rnd3_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw3_reg  <= raw3_next;
            rnd3_reg  <= rnd3_next;
            dsum3_reg <= dsum3_next;
            op3_reg   <= op2_reg;
        end
    end

    // Stage 4: round to nearest with ties upward, saturate the dot product.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rs4[i]       = (AW + 1)'(raw3_reg[i]) + HALF_Q;
            pre4_next[i] = rnd3_reg ? MW'(rs4[i] >>> FB) : MW'(raw3_reg[i]);
        end
        dx4  = DXW'(dsum3_reg);
        dok4 = (&dx4[DXW-1:DOT_WIDTH-1]) || !(|dx4[DXW-1:DOT_WIDTH-1]);
        if (op3_reg != OP_DOT)
        begin
            dot4_next  = '0;
            dsat4_next = 1'b0;
        end
        else if (dok4)
        begin
            dot4_next  = dx4[DOT_WIDTH-1:0];
            dsat4_next = 1'b0;
        end
        else
        begin
            dot4_next  = {dx4[DXW-1], {(DOT_WIDTH - 1){~dx4[DXW-1]}}};
            dsat4_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre4_reg  <= pre4_next;
            dot4_reg  <= dot4_next;
            dsat4_reg <= dsat4_next;
            op4_reg   <= op3_reg;
        end
    end

    // Stages 5 and 6: squares and their sum.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                sq5_reg[i] <= pre4_reg[i] * pre4_reg[i];
            end
            pre5_reg  <= pre4_reg;
            dot5_reg  <= dot4_reg;
            dsat5_reg <= dsat4_reg;
            op5_reg   <= op4_reg;

            s6_reg    <= SW'(sq5_reg[0]) + SW'(sq5_reg[1])
                       + SW'(sq5_reg[2]) + SW'(sq5_reg[3]);
            pre6_reg  <= pre5_reg;
            dot6_reg  <= dot5_reg;
            dsat6_reg <= dsat5_reg;
            op6_reg   <= op5_reg;
        end
    end

    // Stage 7: decide whether the result is normalized and whether it falls back.
    always_comb
    begin
        sx7       = CMPW'(s6_reg);
        dev7      = (sx7 >= UNIT_Q) ? (sx7 - UNIT_Q) : (UNIT_Q - sx7);
        small7    = (s6_reg == '0) || (sx7 < CMPW'(tol));
        inv_norm7 = !(dev7 < CMPW'(thr));
        ctl7_next.op       = op6_reg;
        ctl7_next.use_norm = (op6_reg == OP_NORM) || (op6_reg == OP_NLERP)
                           || ((op6_reg == OP_INV) && inv_norm7);
        ctl7_next.fell_back = ctl7_next.use_norm && small7;
        ctl7_next.dot_sat   = dsat6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_reg   <= s6_reg;
            pre7_reg <= pre6_reg;
            dot7_reg <= dot6_reg;
            ctl7_reg <= ctl7_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pre[i] = pre7_reg[i];
        end
    end

    assign vld    = vld_reg[7];
    assign dot    = dot7_reg;
    assign ctl    = ctl7_reg;
    assign sum_sq = s7_reg;

endmodule

`default_nettype wire

// ===== rtl/core/qau_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
// Depends on qau_pkg.
`default_nettype none

module qau_sqrt
    import qau_pkg::*;
#(
    parameter int IW = 2 * ((qau_sw(COMP_WIDTH_DEF, FRAC_BITS_DEF) + GUARD_SHIFT + 1) / 2)
) (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [IW-1:0]   rad,
    output logic [IW/2-1:0]      root
);

    localparam int OW   = IW / 2;
    localparam int REMW = OW + 3;

    logic [REMW-1:0] rem_reg  [OW];
    logic [OW-1:0]   root_reg [OW];
    logic [IW-1:0]   rad_reg  [OW];

    for (genvar k = 0; k < OW; k++)
    begin : g_stage
        logic [REMW-1:0] rem_in;
        logic [OW-1:0]   root_in;
        logic [IW-1:0]   rad_in;
        logic [REMW-1:0] rem_sh;
        logic [REMW-1:0] trial;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        assign rem_sh = {rem_in[REMW-3:0], rad_in[IW-1:IW-2]};
        assign trial  = REMW'({root_in, 2'b01});
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_in[OW-2:0], ge};
                rad_reg[k]  <= rad_in << 2;
            end
        end
    end

    assign root = root_reg[OW-1];

endmodule

`default_nettype wire

// ===== rtl/core/qau_div_lane.sv =====
// One normalize lane: scales a component by the reciprocal length with a
// pipelined restoring divider, one quotient bit per stage. Depends on qau_pkg.
`default_nettype none

module qau_div_lane
    import qau_pkg::*;
#(
    parameter int MW  = qau_mw(COMP_WIDTH_DEF, FRAC_BITS_DEF),
    parameter int RTW = (qau_sw(COMP_WIDTH_DEF, FRAC_BITS_DEF) + GUARD_SHIFT + 1) / 2,
    parameter int FB  = FRAC_BITS_DEF,
    parameter int QW  = FRAC_BITS_DEF + 2
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [MW-1:0] comp,
    input  wire logic [RTW-1:0]       root,
    output logic [QW-1:0]             quot,
    output logic                      neg
);

    localparam int SH  = FB + GUARD_SHIFT / 2 + 1;
    localparam int NW  = qau_max(MW + SH, RTW) + 1;
    localparam int DW  = RTW + 1;
    localparam int RMW = DW + 1;

    logic [MW-1:0]  mag;
    logic [NW-1:0]  num;

    logic [RMW-1:0] remp_reg;
    logic [QW-1:0]  lowp_reg;
    logic [DW-1:0]  dp_reg;
    logic           negp_reg;

    logic [RMW-1:0] rem_reg  [QW];
    logic [QW-1:0]  low_reg  [QW];
    logic [QW-1:0]  q_reg    [QW];
    logic [DW-1:0]  d_reg    [QW];
    logic           neg_reg  [QW];

    // Rounded quotient: (|c| * 2^SH + root) / (2 * root).
    assign mag = comp[MW-1] ? MW'(-comp) : MW'(comp);
    assign num = (NW'(mag) << SH) + NW'(root);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            remp_reg <= RMW'(num >> QW);
            lowp_reg <= num[QW-1:0];
            dp_reg   <= {root, 1'b0};
            negp_reg <= comp[MW-1];
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [RMW-1:0] rem_in;
        logic [QW-1:0]  low_in;
        logic [QW-1:0]  q_in;
        logic [DW-1:0]  d_in;
        logic           neg_in;
        logic [RMW:0]   trial;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign rem_in = remp_reg;
            assign low_in = lowp_reg;
            assign q_in   = '0;
            assign d_in   = dp_reg;
            assign neg_in = negp_reg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign neg_in = neg_reg[k-1];
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign ge    = (trial >= (RMW + 1)'(d_in));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? RMW'(trial - (RMW + 1)'(d_in)) : RMW'(trial);
                low_reg[k] <= low_in << 1;
                q_reg[k]   <= (q_in << 1) | QW'(ge);
                d_reg[k]   <= d_in;
                neg_reg[k] <= neg_in;
            end
        end
    end

    assign quot = q_reg[QW-1];
    assign neg  = neg_reg[QW-1];

endmodule

`default_nettype wire

// ===== rtl/core/quaternion_arith_unit.sv =====
// Top level of the quaternion arithmetic unit: front pipeline, square root,
// four normalize lanes and the merge stage. Depends on qau_pkg, qau_front,
// qau_sqrt and qau_div_lane.
`default_nettype none

// The unit takes one word per cycle and returns one result word per input word,
// in order, through a fixed pipeline of 7 + R + Q + 2 register stages, the
// first loaded at the accepting edge, where R is the number of root bits of the
// pipelined square root and Q = FRAC_BITS + 2 is the number of quotient bits of
// each normalize lane; with the default widths R is 31 and Q is 16, giving 56
// stages. The pipeline moves as a whole: it advances whenever its last stage is
// empty or the output register is free or being taken, so input stalls only
// while a finished word waits at the output and another sits right behind it.
// The registers are read deep in the pipeline, so write them only while no word
// is in flight.
module quaternion_arith_unit
    import qau_pkg::*;
#(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [REG_W-1:0]             cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [3:0]                   operation,
    input  wire logic signed [COMP_WIDTH-1:0] a_x,
    input  wire logic signed [COMP_WIDTH-1:0] a_y,
    input  wire logic signed [COMP_WIDTH-1:0] a_z,
    input  wire logic signed [COMP_WIDTH-1:0] a_w,
    input  wire logic signed [COMP_WIDTH-1:0] b_x,
    input  wire logic signed [COMP_WIDTH-1:0] b_y,
    input  wire logic signed [COMP_WIDTH-1:0] b_z,
    input  wire logic signed [COMP_WIDTH-1:0] b_w,
    input  wire logic signed [COMP_WIDTH-1:0] blend,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [COMP_WIDTH-1:0]      r_x,
    output logic signed [COMP_WIDTH-1:0]      r_y,
    output logic signed [COMP_WIDTH-1:0]      r_z,
    output logic signed [COMP_WIDTH-1:0]      r_w,
    output logic signed [DOT_WIDTH-1:0]       dot_out,
    output logic                              saturated,
    output logic                              fell_back
);

    localparam int CW  = COMP_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int MW  = qau_mw(CW, FB);
    localparam int SW  = qau_sw(CW, FB);
    localparam int RTW = (SW + GUARD_SHIFT + 1) / 2;
    localparam int IW  = 2 * RTW;
    localparam int QW  = FB + 2;
    localparam int EW  = qau_max(MW, QW + 1) + 1;

    localparam logic signed [EW-1:0] ONE_E = EW'(1) << FB;

    typedef struct packed {
        logic [3:0][MW-1:0]   pre;
        logic [DOT_WIDTH-1:0] dot;
        ctl_t                 ctl;
    } bundle_t;

    logic [REG_W-1:0] tol_reg;
    logic [REG_W-1:0] thr_reg;

    logic               en;
    logic               f_vld;
    logic [3:0][MW-1:0] f_pre;
    logic [DOT_WIDTH-1:0] f_dot;
    ctl_t               f_ctl;
    logic [SW-1:0]      f_sum;
    bundle_t            f_bundle;
    logic [RTW-1:0]     root;

    bundle_t            b1_reg [RTW];
    logic [RTW-1:0]     v1_reg;
    bundle_t            b2_reg [QW+1];
    logic [QW:0]        v2_reg;

    logic [QW-1:0]      quot [4];
    logic               qneg [4];

    bundle_t                fin;
    logic signed [EW-1:0]   nq_c  [4];
    logic signed [EW-1:0]   sel_c [4];
    logic [CW-1:0]          res_c [4];
    logic [3:0]             clip_c;
    logic                   take;

    logic [CW-1:0]          r_reg [4];
    logic [DOT_WIDTH-1:0]   dot_reg;
    logic                   sat_reg;
    logic                   fb_reg;
    logic                   out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= NORM_TOL_RESET;
            thr_reg <= UNIT_THR_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_NORM_TOL)
            begin
                tol_reg <= cfg_data;
            end
            if (cfg_index == CFG_UNIT_THR)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    assign take     = !out_valid_reg || !out_stall;
    assign en       = !v2_reg[QW] || take;
    assign in_stall = !en;

    qau_front #(
        .COMP_WIDTH (COMP_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .tol       (tol_reg),
        .thr       (thr_reg),
        .in_valid  (in_valid),
        .operation (operation),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .a_w       (a_w),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .b_w       (b_w),
        .blend     (blend),
        .vld       (f_vld),
        .pre       (f_pre),
        .dot       (f_dot),
        .ctl       (f_ctl),
        .sum_sq    (f_sum)
    );

    assign f_bundle.pre = f_pre;
    assign f_bundle.dot = f_dot;
    assign f_bundle.ctl = f_ctl;

    qau_sqrt #(
        .IW (IW)
    ) u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (IW'({f_sum, {GUARD_SHIFT{1'b0}}})),
        .root (root)
    );

    // The word waits beside the square root, then beside the lanes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= '0;
            v2_reg <= '0;
        end
        else if (en)
        begin
            v1_reg <= (v1_reg << 1) | RTW'(f_vld);
            v2_reg <= (v2_reg << 1) | (QW + 1)'(v1_reg[RTW-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg[0] <= f_bundle;
            for (int k = 1; k < RTW; k++)
            begin
                b1_reg[k] <= b1_reg[k-1];
            end
            b2_reg[0] <= b1_reg[RTW-1];
            for (int k = 1; k <= QW; k++)
            begin
                b2_reg[k] <= b2_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        qau_div_lane #(
            .MW  (MW),
            .RTW (RTW),
            .FB  (FB),
            .QW  (QW)
        ) u_lane (
            .clk  (clk),
            .en   (en),
            .comp ($signed(b1_reg[RTW-1].pre[i])),
            .root (root),
            .quot (quot[i]),
            .neg  (qneg[i])
        );
    end

    // Merge: pick the lane results, the identity on fallback or the direct result,
    // negate the vector part for inverse, then clip to the component range.
    assign fin = b2_reg[QW];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            nq_c[i] = qneg[i] ? -$signed(EW'(quot[i])) : $signed(EW'(quot[i]));
            if (fin.ctl.use_norm)
            begin
                if (fin.ctl.fell_back)
                begin
                    sel_c[i] = (i == 3) ? ONE_E : '0;
                end
                else
                begin
                    sel_c[i] = nq_c[i];
                end
            end
            else
            begin
                sel_c[i] = EW'($signed(fin.pre[i]));
            end
            if ((fin.ctl.op == OP_INV) && (i < 3))
            begin
                sel_c[i] = -sel_c[i];
            end
            if ((&sel_c[i][EW-1:CW-1]) || !(|sel_c[i][EW-1:CW-1]))
            begin
                res_c[i]  = sel_c[i][CW-1:0];
                clip_c[i] = 1'b0;
            end
            else
            begin
                res_c[i]  = {sel_c[i][EW-1], {(CW - 1){~sel_c[i][EW-1]}}};
                clip_c[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= v2_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            r_reg   <= res_c;
            dot_reg <= fin.dot;
            sat_reg <= (|clip_c) || fin.ctl.dot_sat;
            fb_reg  <= fin.ctl.fell_back;
        end
    end

    assign out_valid = out_valid_reg;
    assign r_x       = r_reg[0];
    assign r_y       = r_reg[1];
    assign r_z       = r_reg[2];
    assign r_w       = r_reg[3];
    assign dot_out   = dot_reg;
    assign saturated = sat_reg;
    assign fell_back = fb_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the output could move");

    a_fallback_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fell_back) |-> (r_x == '0 && r_y == '0 && r_z == '0))
        else $error("fallback result carries a vector part");

    a_dot_excludes_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dot_out != '0) |->
            (r_x == '0 && r_y == '0 && r_z == '0 && r_w == '0 && !fell_back))
        else $error("dot result mixed with a quaternion result");

    a_output_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && v2_reg[QW]) |=> $stable(v2_reg))
        else $error("pipeline moved while the output was blocked");

endmodule

`default_nettype wire

// ===== tb/sv/quaternion_arith_unit_checker.sv =====
// Checker for the quaternion arithmetic unit: mirrors the two registers,
// predicts each result word and compares it in order with the output channel.
// Depends on qau_pkg; instantiated next to the unit by the testbench top.
module quaternion_arith_unit_checker
    import qau_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [REG_W-1:0]  cfg_data,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [3:0]        operation,
    input  logic signed [15:0] a_x, a_y, a_z, a_w,
    input  logic signed [15:0] b_x, b_y, b_z, b_w,
    input  logic signed [15:0] blend,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic signed [15:0] r_x, r_y, r_z, r_w,
    input  logic signed [31:0] dot_out,
    input  logic              saturated,
    input  logic              fell_back,
    output int                errors,
    output int                pending
);

    localparam int FB = FRAC_BITS_DEF;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
        logic signed [31:0] dot;
        logic               sat;
        logic               fb;
    } quat_word_t;

    logic [31:0] tol_reg;
    logic [31:0] thr_reg;
    quat_word_t  expected_words[$];

    function automatic longint round_q(input longint v);
        return (v + (64'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    function automatic longint clip(input longint v, input longint hi, inout bit f);
        if (v > hi)
        begin
            f = 1'b1;
            return hi;
        end
        if (v < -hi - 1)
        begin
            f = 1'b1;
            return -hi - 1;
        end
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned sq_sum(input longint c[4]);
        longint unsigned s;
        s = 0;
        for (int i = 0; i < 4; i++)
            s += longint'(c[i] * c[i]);
        return s;
    endfunction

    function automatic bit unit_scale(input longint c[4], output longint r[4]);
        longint unsigned s;
        longint unsigned root;
        longint unsigned mag;
        longint unsigned q;
        s = sq_sum(c);
        if (s == 0 || s < tol_reg)
        begin
            r[0] = 0;
            r[1] = 0;
            r[2] = 0;
            r[3] = 64'sd1 <<< FB;
            return 1'b1;
        end
        root = int_sqrt(s << GUARD_SHIFT);
        if (root == 0)
            root = 1;
        for (int i = 0; i < 4; i++)
        begin
            mag = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
            q = ((mag << (FB + GUARD_SHIFT / 2 + 1)) + root) / (2 * root);
            r[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b0;
    endfunction

    function automatic quat_word_t quat_compute(input logic [3:0] op, input longint a[4],
                                                input longint b[4], input longint t);
        quat_word_t res;
        longint r[4];
        longint mix[4];
        longint dot;
        longint unsigned s;
        longint unsigned dev;
        longint unsigned unit;
        bit sat;
        bit fb;
        r = '{0, 0, 0, 0};
        dot = 0;
        sat = 0;
        fb = 0;
        case (op)
            OP_MUL:
            begin
                r[0] = round_q(a[1]*b[2] - a[2]*b[1] + b[0]*a[3] + a[0]*b[3]);
                r[1] = round_q(a[2]*b[0] - a[0]*b[2] + b[1]*a[3] + a[1]*b[3]);
                r[2] = round_q(a[0]*b[1] - a[1]*b[0] + b[2]*a[3] + a[2]*b[3]);
                r[3] = round_q(a[3]*b[3] - (a[0]*b[0] + a[1]*b[1] + a[2]*b[2]));
            end
            OP_ADD:
                for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
            OP_SUB:
                for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
            OP_SCALE:
                for (int i = 0; i < 4; i++) r[i] = round_q(a[i] * t);
            OP_CONJ:
                r = '{-a[0], -a[1], -a[2], a[3]};
            OP_NORM:
                fb = unit_scale(a, r);
            OP_INV:
            begin
                s = sq_sum(a);
                unit = 64'd1 << (2 * FB);
                dev = (s >= unit) ? s - unit : unit - s;
                if (dev < thr_reg)
                    r = a;
                else
                    fb = unit_scale(a, r);
                r[0] = -r[0];
                r[1] = -r[1];
                r[2] = -r[2];
            end
            OP_NLERP:
            begin
                for (int i = 0; i < 4; i++)
                    mix[i] = round_q(a[i] * ((64'sd1 <<< FB) - t) + b[i] * t);
                fb = unit_scale(mix, r);
            end
            OP_DOT:
            begin
                dot = a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3];
                dot = clip(dot, 64'sd2147483647, sat);
            end
            default:
                ;
        endcase
        res.x = 16'(clip(r[0], 64'sd32767, sat));
        res.y = 16'(clip(r[1], 64'sd32767, sat));
        res.z = 16'(clip(r[2], 64'sd32767, sat));
        res.w = 16'(clip(r[3], 64'sd32767, sat));
        res.dot = 32'(dot);
        res.sat = sat;
        res.fb = fb;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        quat_word_t got;
        quat_word_t exp_w;
        if (!rst_n)
        begin
            tol_reg <= NORM_TOL_RESET;
            thr_reg <= UNIT_THR_RESET;
            errors = 0;
            expected_words.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{r_x, r_y, r_z, r_w, dot_out, saturated, fell_back};
                if (expected_words.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected result word: %p", got);
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (got !== exp_w)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("Mismatch: expected %p, got %p", exp_w, got);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_words.push_back(quat_compute(operation,
                    '{a_x, a_y, a_z, a_w}, '{b_x, b_y, b_z, b_w}, blend));
            pending = expected_words.size();
            if (cfg_we)
            begin
                if (cfg_index == CFG_NORM_TOL)
                    tol_reg <= cfg_data;
                else
                    thr_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== tb/sv/quaternion_arith_unit_tb.sv =====
// Testbench top for the quaternion arithmetic unit: clock, reset, register
// writes, directed and random words with random idling, and the verdict.
// Depends on qau_pkg, quaternion_arith_unit and quaternion_arith_unit_checker.
module quaternion_arith_unit_tb;
    import qau_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 70;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic cfg_index = CFG_NORM_TOL;
    logic [REG_W-1:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_stall;
    logic [3:0] operation = OP_MUL;
    logic signed [15:0] a_x = 0, a_y = 0, a_z = 0, a_w = 0;
    logic signed [15:0] b_x = 0, b_y = 0, b_z = 0, b_w = 0;
    logic signed [15:0] blend = 0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [15:0] r_x, r_y, r_z, r_w;
    logic signed [31:0] dot_out;
    logic saturated, fell_back;
    int errors, pending;
    int send_idle = 0, recv_idle = 0;
    int cycles = 0;
    int hold_left = 0;
    bit hold_req = 0;

    quaternion_arith_unit dut (.*);

    quaternion_arith_unit_checker checker_i (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                out_stall = 1;
                hold_left--;
            end
            else
                out_stall = ($urandom_range(99) < recv_idle);
        end
    end

    task automatic send_word(input logic [3:0] op, input logic [15:0] a[4],
                             input logic [15:0] b[4], input logic [15:0] t);
        bit stalled;
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid = 0;
            @(negedge clk);
        end
        in_valid = 1;
        operation = op;
        {a_x, a_y, a_z, a_w} = {a[0], a[1], a[2], a[3]};
        {b_x, b_y, b_z, b_w} = {b[0], b[1], b[2], b[3]};
        blend = t;
        forever
        begin
            #1;
            stalled = in_stall;
            @(posedge clk);
            if (!stalled)
                break;
            @(negedge clk);
        end
    endtask

    task automatic settle_and_write(input logic idx, input logic [31:0] val);
        @(negedge clk);
        in_valid = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 0;
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(4))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(32768)) - 16384);
            2:
                case ($urandom_range(2))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    default: return 16'h0000;
                endcase
            3: return 16'($signed($urandom_range(8)) - 4);
            default: return 16'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    task automatic random_words(input int count);
        logic [15:0] a[4];
        logic [15:0] b[4];
        logic [15:0] t;
        logic [3:0] op;
        int axis;
        for (int n = 0; n < count; n++)
        begin
            op = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
            for (int i = 0; i < 4; i++)
            begin
                a[i] = rand_comp();
                b[i] = rand_comp();
            end
            t = ($urandom_range(1)) ? 16'($urandom_range(16384)) : rand_comp();
            if ($urandom_range(2) == 0)
            begin
                axis = $urandom_range(3);
                for (int i = 0; i < 4; i++)
                begin
                    a[i] = 16'($signed($urandom_range(16)) - 8);
                    b[i] = 16'($signed($urandom_range(16)) - 8);
                end
                a[axis] = a[axis] + ($urandom_range(1) ? 16'sd16384 : -16'sd16384);
                b[3 - axis] = b[3 - axis] + 16'sd16384;
            end
            if (n == count / 3 && send_idle == 0)
                hold_req = 1;
            send_word(op, a, b, t);
        end
    endtask

    initial
    begin
        logic [15:0] zq[4];
        logic [15:0] mn[4];
        logic [15:0] mx[4];
        logic [15:0] id[4];
        logic [15:0] tiny[4];
        zq = '{16'h0, 16'h0, 16'h0, 16'h0};
        mn = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
        mx = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
        id = '{16'h0, 16'h0, 16'h0, 16'd16384};
        tiny = '{16'd1, 16'h0, 16'h0, 16'h0};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_idle = 34;
        recv_idle = 68;
        for (int op = OP_MUL; op <= OP_DOT; op++)
        begin
            send_word(4'(op), mn, mn, 16'h8000);
            send_word(4'(op), mx, mn, 16'h7fff);
        end
        send_word(OP_NORM, zq, zq, 16'h0);
        send_word(OP_NORM, tiny, zq, 16'h0);
        send_word(OP_INV, id, zq, 16'h0);
        send_word(OP_INV, '{16'h8000, 16'h0, 16'h0, 16'h0}, zq, 16'h0);
        send_word(OP_NLERP, id, mx, 16'h0);
        send_word(OP_NLERP, id, mn, 16'd16384);
        send_word(4'd15, mx, mx, 16'h7fff);
        random_words(400);

        settle_and_write(CFG_NORM_TOL, 32'h0);
        settle_and_write(CFG_UNIT_THR, 32'hffffffff);
        send_idle = 68;
        recv_idle = 34;
        random_words(400);

        settle_and_write(CFG_NORM_TOL, 32'hffffffff);
        settle_and_write(CFG_UNIT_THR, 32'h0);
        send_idle = 0;
        recv_idle = 0;
        random_words(400);

        settle_and_write(CFG_NORM_TOL, $urandom);
        settle_and_write(CFG_UNIT_THR, $urandom);
        random_words(200);
        settle_and_write(CFG_NORM_TOL, $urandom_range(1 << 20));
        settle_and_write(CFG_UNIT_THR, $urandom_range(1 << 24));
        random_words(200);

        @(negedge clk);
        in_valid = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/qau_pkg.sv
rtl/core/qau_front.sv
rtl/core/qau_sqrt.sv
rtl/core/qau_div_lane.sv
rtl/core/quaternion_arith_unit.sv
tb/sv/quaternion_arith_unit_checker.sv
tb/sv/quaternion_arith_unit_tb.sv
